// ----- hdl/dq_pkg.sv -----
`default_nettype none

package dq_pkg;

    // Defaults for the top-level parameters
    localparam int DQ_DEPTH      = 32;
    localparam int DQ_DATA_WIDTH = 32;

    // Fixed field widths of the channels
    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 6;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5,
        OP_FIND       = 3'd6,
        OP_REMOVE     = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- hdl/dq_req_if.sv -----
`default_nettype none

interface dq_req_if import dq_pkg::*;
();
    logic               valid;
    logic               ready;
    op_t                op;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

// ----- hdl/dq_rsp_if.sv -----
`default_nettype none

interface dq_rsp_if import dq_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] result_value;
    status_t            status;
    logic [OCC_W-1:0]   occupancy;

    modport source (output valid, output result_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input result_value, input status, input occupancy,
                    output ready);
endinterface

`default_nettype wire

// ----- hdl/dq_ram.sv -----
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bounded_deque_with_search.sv -----
`default_nettype none

// Channel | Dir | Beat contents                          | Modport
// --------+-----+----------------------------------------+----------------
// req     | in  | op, value                              | dq_req_if.sink
// rsp     | out | result_value, status, occupancy        | dq_rsp_if.source
//
// One request at a time. Find scans from the front up to the first match; remove
// scans up to the match, then shifts the tail. One entry store read per cycle.
// Reset clears front index, count and control; the entry store is not cleared.
// A result waits in the output register while the next request is accepted; the
// block holds in its final step only if that register is still occupied.

module bounded_deque_with_search import dq_pkg::*; #(
    parameter int DEPTH      = DQ_DEPTH,
    parameter int DATA_WIDTH = DQ_DATA_WIDTH
) (
    input wire logic clk,
    input wire logic rst_n,
    dq_req_if.sink   req,
    dq_rsp_if.source rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Map a position counted from the front to a ring slot
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                              input logic [CW-1:0] pos);
        logic [CW:0] sum;
        sum = (CW+1)'(front) + (CW+1)'(pos);
        if (sum >= (CW+1)'(DEPTH))
        begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return AW'(sum);
    endfunction

    // Control state
    state_t          state_reg, state_next;
    logic [AW-1:0]   front_reg, front_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   pos_reg, pos_next;       // next position to read
    logic            chk_reg, chk_next;       // read data of chk_pos is valid
    logic            rsp_valid_reg, rsp_valid_next;

    // Payload
    op_t             op_reg, op_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;
    logic [DATA_WIDTH-1:0] res_reg, res_next;
    status_t         stat_reg, stat_next;
    logic [CW-1:0]   chk_pos_reg, chk_pos_next;
    logic [VALUE_W-1:0] rsp_value_reg, rsp_value_next;
    status_t         rsp_status_reg, rsp_status_next;
    logic [OCC_W-1:0] rsp_occ_reg, rsp_occ_next;

    // Entry store port
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    logic                  accept;
    logic                  full;
    logic                  empty;
    logic                  issue;
    logic [AW-1:0]         front_dec;
    logic [AW-1:0]         front_inc;
    logic [DATA_WIDTH-1:0] key_in;

    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req.ready        = (state_reg == S_IDLE);
    assign accept           = req.valid && req.ready;
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.result_value = rsp_value_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.occupancy    = rsp_occ_reg;

    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign issue     = (pos_reg < count_reg);
    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - AW'(1);
    assign front_inc = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + AW'(1);
    assign key_in    = DATA_WIDTH'(req.value);

    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        chk_next        = chk_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        res_next        = res_reg;
        stat_next       = stat_reg;
        chk_pos_next    = chk_pos_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_value_next  = rsp_value_reg;
        rsp_status_next = rsp_status_reg;
        rsp_occ_next    = rsp_occ_reg;
        wr_en           = 1'b0;
        wr_addr         = front_reg;
        wr_data         = key_in;
        rd_en           = 1'b0;
        rd_addr         = front_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = req.op;
                    key_next = key_in;
                    res_next = '0;
                    pos_next = '0;
                    chk_next = 1'b0;
                    unique case (req.op)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            state_next = S_DONE;
                            if (full)
                            begin
                                stat_next = ST_FULL;
                            end
                            else
                            begin
                                stat_next  = ST_OK;
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                                if (req.op == OP_PUSH_FRONT)
                                begin
                                    wr_addr    = front_dec;
                                    front_next = front_dec;
                                end
                                else
                                begin
                                    wr_addr = slot_of(front_reg, count_reg);
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK:
                        begin
                            if (empty)
                            begin
                                stat_next  = ST_EMPTY;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = S_READ;
                                if (req.op == OP_POP_BACK || req.op == OP_PEEK_BACK)
                                begin
                                    rd_addr = slot_of(front_reg, count_reg - CW'(1));
                                end
                            end
                        end
                        OP_FIND, OP_REMOVE:
                        begin
                            stat_next  = ST_NOT_FOUND;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                res_next   = rd_data;
                stat_next  = ST_OK;
                state_next = S_DONE;
                if (op_reg == OP_POP_FRONT)
                begin
                    front_next = front_inc;
                    count_next = count_reg - CW'(1);
                end
                else if (op_reg == OP_POP_BACK)
                begin
                    count_next = count_reg - CW'(1);
                end
            end

            S_SCAN:
            begin
                if (chk_reg && rd_data == key_reg)
                begin
                    // First match from the front
                    res_next  = rd_data;
                    stat_next = ST_OK;
                    chk_next  = 1'b0;
                    if (op_reg == OP_REMOVE)
                    begin
                        pos_next   = chk_pos_reg + CW'(1);
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    chk_next = issue;
                    if (issue)
                    begin
                        rd_en        = 1'b1;
                        rd_addr      = slot_of(front_reg, pos_reg);
                        chk_pos_next = pos_reg;
                        pos_next     = pos_reg + CW'(1);
                    end
                    else if (!chk_reg)
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_SHIFT:
            begin
                // Read entry pos, write it one place toward the front next cycle
                chk_next = issue;
                if (issue)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = slot_of(front_reg, pos_reg);
                    chk_pos_next = pos_reg;
                    pos_next     = pos_reg + CW'(1);
                end
                if (chk_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = slot_of(front_reg, chk_pos_reg - CW'(1));
                    wr_data = rd_data;
                end
                if (!issue && !chk_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // Hold until the output register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_value_next  = VALUE_W'(res_reg);
                    rsp_status_next = stat_reg;
                    rsp_occ_next    = OCC_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            chk_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            chk_reg       <= chk_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        res_reg        <= res_next;
        stat_reg       <= stat_next;
        chk_pos_reg    <= chk_pos_next;
        rsp_value_reg  <= rsp_value_next;
        rsp_status_reg <= rsp_status_next;
        rsp_occ_reg    <= rsp_occ_next;
    end

endmodule

`default_nettype wire
